// File: design/rank_select_permutation_decoder_unit_macros.svh
// Assertion macros for the top design file.
`ifndef RANK_SELECT_PERMUTATION_DECODER_UNIT_MACROS_SVH
`define RANK_SELECT_PERMUTATION_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rsp_pkg.sv
`default_nettype none
package rsp_pkg;

	localparam int MAX_VALUES = 64;
	localparam int POS_W      = $clog2(MAX_VALUES);
	localparam int CNT_W      = $clog2(MAX_VALUES + 1);
	localparam int RANK_W     = 6;
	localparam int VAL_W      = 7;
	localparam int SIZE_W     = 7;
	localparam int CMP_W      = 8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_DONE
	} rsp_state_t;

	typedef struct packed {
		logic refill;
		logic load;
		logic step;
		logic take;
		logic fail;
	} rsp_cmd_t;

	typedef struct packed {
		logic             failed;
		logic             too_big;
		logic             hit;
		logic             last;
		logic [POS_W-1:0] pos;
	} rsp_stat_t;

endpackage
`default_nettype wire

// File: design/rsp_in_if.sv
`default_nettype none
interface rsp_in_if;
	import rsp_pkg::*;

	logic              valid;
	logic              ready;
	logic              start_new;
	logic [RANK_W-1:0] rank_from_top;

	modport source (output valid, output start_new, output rank_from_top, input ready);
	modport sink (input valid, input start_new, input rank_from_top, output ready);

endinterface
`default_nettype wire

// File: design/rsp_out_if.sv
`default_nettype none
interface rsp_out_if;
	import rsp_pkg::*;

	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] picked_value;
	logic             impossible;

	modport source (output valid, output picked_value, output impossible, input ready);
	modport sink (input valid, input picked_value, input impossible, output ready);

endinterface
`default_nettype wire

// File: design/rsp_set.sv
`default_nettype none
module rsp_set
	import rsp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rsp_cmd_t          cmd,
	input  wire logic [SIZE_W-1:0] set_size,
	input  wire logic [RANK_W-1:0] rank,
	output rsp_stat_t              stat
);

	logic [MAX_VALUES-1:0] map_q;
	logic [CNT_W-1:0]      count_q;
	logic                  failed_q;
	logic [POS_W-1:0]      pos_q;
	logic [RANK_W-1:0]     left_q;

	logic [SIZE_W-1:0]     fill_n;
	logic [MAX_VALUES-1:0] fill_map;
	logic                  cur_bit;

	always_comb begin
		if (set_size > SIZE_W'(MAX_VALUES)) begin
			fill_n = SIZE_W'(MAX_VALUES);
		end else begin
			fill_n = set_size;
		end
		for (int i = 0; i < MAX_VALUES; i++) begin
			fill_map[i] = CMP_W'(i) < CMP_W'(fill_n);
		end
	end

	assign cur_bit      = map_q[pos_q];
	assign stat.failed  = failed_q;
	assign stat.too_big = CMP_W'(left_q) >= CMP_W'(count_q);
	assign stat.hit     = cur_bit && (left_q == '0);
	assign stat.last    = pos_q == '0;
	assign stat.pos     = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q    <= '0;
			count_q  <= '0;
			failed_q <= 1'b0;
		end else begin
			if (cmd.refill) begin
				map_q    <= fill_map;
				count_q  <= CNT_W'(fill_n);
				failed_q <= 1'b0;
			end else if (cmd.take) begin
				map_q[pos_q] <= 1'b0;
				count_q      <= count_q - CNT_W'(1);
			end else if (cmd.fail) begin
				failed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q  <= POS_W'(MAX_VALUES - 1);
			left_q <= rank;
		end else if (cmd.step) begin
			pos_q <= pos_q - POS_W'(1);
			if (cur_bit && !stat.hit) begin
				left_q <= left_q - RANK_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// File: design/rank_select_permutation_decoder_unit.sv
// Channel  Dir  Fields                        Transfer
// code     in   start_new, rank_from_top     valid && ready
// pick     out  picked_value, impossible     valid && ready
// cfg      in   set_size_wdata               set_size_we
// After its transfer an item passes the check step, the scan unless the check fails, then done.
// A new transfer is taken only once the result is in the output register and the block is idle.
// The scan tests one map position per cycle from the top and stops at a hit or at position 0.
// A rank out of range, or a sticky failure, skips the scan and goes from check straight to done.
// Reset empties the value set, clears the failure and sets set_size to 64.
// A result waits in the output register while the next item is taken and processed.
`default_nettype none
`include "rank_select_permutation_decoder_unit_macros.svh"
module rank_select_permutation_decoder_unit
	import rsp_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	rsp_in_if.sink                 code,
	rsp_out_if.source              pick,
	input  wire logic              set_size_we,
	input  wire logic [SIZE_W-1:0] set_size_wdata
);

	rsp_state_t        state_q;
	rsp_state_t        state_d;
	rsp_cmd_t          cmd;
	rsp_stat_t         stat;
	logic [SIZE_W-1:0] set_size_q;
	logic [VAL_W-1:0]  res_val_q;
	logic              res_imp_q;
	logic              res_load;
	logic [VAL_W-1:0]  res_val_d;
	logic              res_imp_d;
	logic              out_valid_q;
	logic [VAL_W-1:0]  out_val_q;
	logic              out_imp_q;
	logic              out_free;
	logic              in_xfer;

	assign in_xfer  = code.valid && code.ready;
	assign out_free = !out_valid_q || pick.ready;

	rsp_set u_set (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.set_size (set_size_q),
		.rank     (code.rank_from_top),
		.stat     (stat)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (code.valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.failed || stat.too_big) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.hit || stat.last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		code.ready = 1'b0;
		res_load   = 1'b0;
		res_val_d  = '0;
		res_imp_d  = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				code.ready = 1'b1;
				cmd.load   = code.valid;
				cmd.refill = code.valid && code.start_new;
			end
			ST_CHECK: begin
				if (stat.failed || stat.too_big) begin
					cmd.fail = 1'b1;
					res_load = 1'b1;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (stat.hit) begin
					cmd.take  = 1'b1;
					res_load  = 1'b1;
					res_val_d = VAL_W'(stat.pos) + VAL_W'(1);
					res_imp_d = 1'b0;
				end else if (stat.last) begin
					cmd.fail = 1'b1;
					res_load = 1'b1;
				end
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			set_size_q  <= SIZE_W'(64);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (set_size_we) begin
				set_size_q <= set_size_wdata;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (pick.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_val_q <= res_val_d;
			res_imp_q <= res_imp_d;
		end
		if (state_q == ST_DONE && out_free) begin
			out_val_q <= res_val_q;
			out_imp_q <= res_imp_q;
		end
	end

	assign pick.valid        = out_valid_q;
	assign pick.picked_value = out_val_q;
	assign pick.impossible   = out_imp_q;

	`RSP_ASSERT_NEXT(a_xfer_to_check, clk, arst_n, in_xfer, state_q == ST_CHECK,
		"accepted item did not enter the check step")
	`RSP_ASSERT_NEXT(a_hit_result_ok, clk, arst_n, state_q == ST_SCAN && stat.hit,
		state_q == ST_DONE && !res_imp_q && res_val_q != '0,
		"scan hit did not produce a valid pick")
	`RSP_ASSERT_NEXT(a_sticky_fail, clk, arst_n, state_q == ST_CHECK && stat.failed,
		res_imp_q && stat.failed, "sticky failure did not yield an impossible result")
	`RSP_ASSERT_SAME(a_pick_nonzero, clk, arst_n, pick.valid && !pick.impossible,
		pick.picked_value != '0, "possible result carries value zero")

endmodule
`default_nettype wire

// File: tb/rank_select_permutation_decoder_unit_tb.sv
`timescale 1ns / 1ps
module rank_select_permutation_decoder_unit_tb;
	import rsp_pkg::*;

	typedef struct packed {
		logic [VAL_W-1:0] value;
		logic             imp;
	} pick_t;

	typedef struct packed {
		logic              cfg;
		logic [SIZE_W-1:0] size;
		logic              start;
		logic [RANK_W-1:0] rank;
		logic              typed;
		logic [VAL_W-1:0]  value;
		logic              imp;
	} code_row_t;

	localparam int PLAN_LEN = 23;
	localparam code_row_t PLAN [PLAN_LEN] = '{
		'{1'b0, 7'd0,   1'b0, 6'd0,  1'b1, 7'd0,  1'b1},
		'{1'b0, 7'd0,   1'b0, 6'd63, 1'b1, 7'd0,  1'b1},
		'{1'b0, 7'd0,   1'b1, 6'd0,  1'b1, 7'd64, 1'b0},
		'{1'b0, 7'd0,   1'b0, 6'd0,  1'b1, 7'd63, 1'b0},
		'{1'b0, 7'd0,   1'b0, 6'd61, 1'b1, 7'd1,  1'b0},
		'{1'b0, 7'd0,   1'b0, 6'd61, 1'b1, 7'd0,  1'b1},
		'{1'b0, 7'd0,   1'b0, 6'd0,  1'b1, 7'd0,  1'b1},
		'{1'b0, 7'd0,   1'b1, 6'd63, 1'b1, 7'd1,  1'b0},
		'{1'b0, 7'd0,   1'b1, 6'd5,  1'b0, 7'd0,  1'b0},
		'{1'b1, 7'd1,   1'b1, 6'd0,  1'b1, 7'd1,  1'b0},
		'{1'b0, 7'd0,   1'b0, 6'd0,  1'b1, 7'd0,  1'b1},
		'{1'b0, 7'd0,   1'b1, 6'd1,  1'b1, 7'd0,  1'b1},
		'{1'b1, 7'd0,   1'b1, 6'd0,  1'b1, 7'd0,  1'b1},
		'{1'b1, 7'd127, 1'b1, 6'd63, 1'b1, 7'd1,  1'b0},
		'{1'b0, 7'd0,   1'b0, 6'd0,  1'b1, 7'd64, 1'b0},
		'{1'b1, 7'd2,   1'b1, 6'd1,  1'b1, 7'd1,  1'b0},
		'{1'b0, 7'd0,   1'b0, 6'd0,  1'b1, 7'd2,  1'b0},
		'{1'b0, 7'd0,   1'b0, 6'd0,  1'b1, 7'd0,  1'b1},
		'{1'b1, 7'd64,  1'b1, 6'd32, 1'b0, 7'd0,  1'b0},
		'{1'b0, 7'd0,   1'b0, 6'd17, 1'b0, 7'd0,  1'b0},
		'{1'b1, 7'd65,  1'b1, 6'd63, 1'b1, 7'd1,  1'b0},
		'{1'b1, 7'd5,   1'b1, 6'd2,  1'b0, 7'd0,  1'b0},
		'{1'b0, 7'd0,   1'b0, 6'd3,  1'b0, 7'd0,  1'b0}
	};

	localparam int PHASES = 12;
	localparam int PHASE_SIZE [PHASES] = '{64, 1, 2, 0, 127, 65, -1, -1, 33, -1, 63, -1};
	localparam int PHASE_CODES = 160;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic              set_size_we;
	logic [SIZE_W-1:0] set_size_wdata;

	rsp_in_if  code ();
	rsp_out_if pick ();

	rank_select_permutation_decoder_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.code           (code),
		.pick           (pick),
		.set_size_we    (set_size_we),
		.set_size_wdata (set_size_wdata)
	);

	always #1 clk = ~clk;

	logic [SIZE_W-1:0]     set_len = 7'd64;
	logic [MAX_VALUES-1:0] avail_map = '0;
	int                    avail_cnt = 0;
	logic                  stuck = 1'b0;

	pick_t picks_due [$];
	int    mismatches = 0;
	int    picks_seen = 0;
	bit    hold_done = 1'b0;

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("mismatch %0d at %0t: %s", mismatches, $realtime, what);
	endtask

	task automatic predict_pick(input logic s, input logic [RANK_W-1:0] r, output pick_t p);
		int n;
		int k;
		int seen;
		int at;
		if (s) begin
			n = set_len;
			if (n > MAX_VALUES)
				n = MAX_VALUES;
			avail_map = (n >= MAX_VALUES) ? '1 : ((MAX_VALUES'(1) << n) - MAX_VALUES'(1));
			avail_cnt = n;
			stuck = 1'b0;
		end
		p = '{value: '0, imp: 1'b1};
		if (stuck || r >= avail_cnt) begin
			stuck = 1'b1;
		end else begin
			k = avail_cnt - 1 - int'(r);
			seen = 0;
			at = MAX_VALUES;
			for (int i = 0; i < MAX_VALUES; i++) begin
				if (avail_map[i] && at == MAX_VALUES) begin
					if (seen == k)
						at = i;
					seen++;
				end
			end
			if (at == MAX_VALUES) begin
				stuck = 1'b1;
			end else begin
				avail_map[at] = 1'b0;
				avail_cnt--;
				p.value = VAL_W'(at + 1);
				p.imp = 1'b0;
			end
		end
	endtask

	function automatic logic [RANK_W-1:0] fair_rank(input int cnt);
		if (cnt > 0)
			return RANK_W'($urandom_range(0, cnt - 1));
		return RANK_W'($urandom_range(0, 63));
	endfunction

	task automatic send_code(input logic s, input logic [RANK_W-1:0] r, input logic typed,
		input logic [VAL_W-1:0] kv, input logic ki);
		int gap;
		pick_t p;
		gap = $urandom_range(0, 9);
		if (gap > 0) begin
			code.valid <= 1'b0;
			code.start_new <= 1'($urandom_range(0, 1));
			code.rank_from_top <= RANK_W'($urandom_range(0, 63));
			repeat (gap) @(posedge clk);
		end
		code.valid <= 1'b1;
		code.start_new <= s;
		code.rank_from_top <= r;
		do @(posedge clk); while (!code.ready);
		predict_pick(s, r, p);
		if (typed)
			p = '{value: kv, imp: ki};
		picks_due = {picks_due, p};
	endtask

	task automatic write_set_size(input logic [SIZE_W-1:0] v);
		code.valid <= 1'b0;
		while (picks_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		set_size_we <= 1'b1;
		set_size_wdata <= v;
		@(posedge clk);
		set_size_we <= 1'b0;
		set_len = v;
	endtask

	initial begin : stimulus
		int size;
		int eff_n;
		int sent;
		int len;
		int roll;
		code.valid <= 1'b0;
		code.start_new <= 1'b0;
		code.rank_from_top <= '0;
		set_size_we <= 1'b0;
		set_size_wdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_LEN; i++) begin
			if (PLAN[i].cfg)
				write_set_size(PLAN[i].size);
			send_code(PLAN[i].start, PLAN[i].rank, PLAN[i].typed, PLAN[i].value, PLAN[i].imp);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			size = PHASE_SIZE[ph];
			if (size < 0)
				size = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 16);
			write_set_size(SIZE_W'(size));
			eff_n = (size > MAX_VALUES) ? MAX_VALUES : size;
			sent = 0;
			while (sent < PHASE_CODES) begin
				send_code(1'b1, fair_rank(eff_n), 1'b0, '0, 1'b0);
				sent++;
				len = (eff_n > 1) ? eff_n - 1 : 0;
				for (int j = 0; j < len; j++) begin
					roll = $urandom_range(0, 29);
					if (roll == 0)
						send_code(1'b0, RANK_W'($urandom_range(0, 63)), 1'b0, '0, 1'b0);
					else if (roll == 1)
						send_code(1'b1, fair_rank(eff_n), 1'b0, '0, 1'b0);
					else
						send_code(1'b0, fair_rank(avail_cnt), 1'b0, '0, 1'b0);
					sent++;
				end
				if ($urandom_range(0, 3) == 0) begin
					send_code(1'b0, RANK_W'($urandom_range(0, 63)), 1'b0, '0, 1'b0);
					sent++;
				end
			end
		end

		code.valid <= 1'b0;
		while (picks_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0 && picks_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin : drain
		int w;
		pick_t want;
		pick.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			w = $urandom_range(0, 9);
			if ($urandom_range(0, 5) == 0)
				w = 0;
			if (!hold_done && picks_seen >= 300) begin
				w = 400;
				hold_done = 1'b1;
			end
			if (w > 0) begin
				pick.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			pick.ready <= 1'b1;
			do @(posedge clk); while (!pick.valid);
			picks_seen++;
			if (picks_due.size() == 0) begin
				flag_mismatch($sformatf("result with nothing due: value %0d impossible %0b",
					pick.picked_value, pick.impossible));
			end else begin
				want = picks_due.pop_front();
				if (pick.picked_value !== want.value)
					flag_mismatch($sformatf("picked_value %0d, want %0d",
						pick.picked_value, want.value));
				if (pick.impossible !== want.imp)
					flag_mismatch($sformatf("impossible %0b, want %0b",
						pick.impossible, want.imp));
			end
		end
	end

	initial begin : watchdog
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
